// ----- rtl/ttf_pkg.sv -----
// Shared types for the triangle tangent frame block: controller states,
// cross-product term codes, and the command/status buses between ctrl and dpath.
// No dependencies.
package ttf_pkg;

  // Digit width of the shared multiplier: one signed operand times one digit per cycle
  localparam int MUL_DIGIT = 17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_DET_TAKE,
    ST_DET_CHK,
    ST_NUM_PREP,
    ST_OVF_CHK,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } ttf_state_t;

  // Position of the next vertex within its triangle
  typedef enum logic [1:0] {
    PH_V0,
    PH_V1,
    PH_V2
  } ttf_phase_t;

  // Which cross product the multiplier is working on
  typedef enum logic [2:0] {
    TERM_DET,
    TERM_TX,
    TERM_TY,
    TERM_TZ,
    TERM_BX,
    TERM_BY,
    TERM_BZ
  } ttf_term_t;

  typedef struct packed {
    logic      load_v1;     // capture first vertex
    logic      load_v2;     // capture second vertex
    logic      load_tri;    // third vertex: capture edges and UV deltas
    logic      acc_clr;     // clear cross-product accumulator
    logic      mul_go;      // issue one partial product
    logic      mul_second;  // partial product belongs to the subtracted term
    ttf_term_t term;        // operand select
    logic      det_take;    // latch |det| and its sign
    logic      num_prep;    // latch |numerator| << FRAC_BITS into the divider
    logic      ovf_chk;     // quotient range check
    logic      div_step;    // one restoring-division step
    logic      res_store;   // write saturated quotient into its slot
    logic      out_load;    // move results into the output register
    logic      degen;       // zero determinant for this triangle
  } ttf_cmd_t;

  typedef struct packed {
    logic det_zero;
  } ttf_stat_t;

endpackage

// ----- rtl/ttf_ctrl.sv -----
// Controller for the triangle tangent frame: vertex phase, sequencing of the
// shared multiplier and serial divider, and both channel handshakes.
// Depends on ttf_pkg.
module ttf_ctrl
  import ttf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  localparam int EW    = DATA_WIDTH + 1,
  localparam int ND    = (EW + MUL_DIGIT - 1) / MUL_DIGIT,
  localparam int DIG_W = (ND > 1) ? $clog2(ND) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output ttf_cmd_t         cmd,
  output logic [DIG_W-1:0] dig,
  input  ttf_stat_t        stat
);

  localparam int QB  = DATA_WIDTH + 1;
  localparam int QCW = $clog2(QB);

  ttf_state_t       state_r, state_nxt;
  ttf_phase_t       phase_r, phase_nxt;
  ttf_term_t        term_r, term_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic             second_r, second_nxt;
  logic [QCW-1:0]   qcnt_r, qcnt_nxt;
  logic             degen_r, degen_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_accept;

  assign in_accept = in_valid && (state_r == ST_IDLE);

  // Next state and counters
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    term_nxt   = term_r;
    dig_nxt    = dig_r;
    second_nxt = second_r;
    qcnt_nxt   = qcnt_r;
    degen_nxt  = degen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (phase_r)
            PH_V1: phase_nxt = PH_V2;
            PH_V2: begin
              phase_nxt  = PH_V0;
              state_nxt  = ST_MUL;
              term_nxt   = TERM_DET;
              dig_nxt    = '0;
              second_nxt = 1'b0;
              degen_nxt  = 1'b0;
            end
            default: phase_nxt = PH_V1;
          endcase
        end
      end
      ST_MUL: begin
        if (dig_r == DIG_W'(ND - 1)) begin
          dig_nxt = '0;
          if (second_r) begin
            second_nxt = 1'b0;
            state_nxt  = ST_DRAIN;
          end else begin
            second_nxt = 1'b1;
          end
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      ST_DRAIN: state_nxt = (term_r == TERM_DET) ? ST_DET_TAKE : ST_NUM_PREP;
      ST_DET_TAKE: state_nxt = ST_DET_CHK;
      ST_DET_CHK: begin
        if (stat.det_zero) begin
          degen_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          term_nxt  = TERM_TX;
          state_nxt = ST_MUL;
        end
      end
      ST_NUM_PREP: state_nxt = ST_OVF_CHK;
      ST_OVF_CHK: begin
        qcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (qcnt_r == QCW'(QB - 1)) begin
          state_nxt = ST_STORE;
        end else begin
          qcnt_nxt = qcnt_r + 1'b1;
        end
      end
      ST_STORE: begin
        if (term_r == TERM_BZ) begin
          state_nxt = ST_DONE;
        end else begin
          term_nxt  = ttf_term_t'(term_r + 3'd1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (cmd.out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Output beat register: set on load, held while stalled
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.term       = term_r;
    cmd.mul_second = second_r;
    cmd.degen      = degen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (phase_r)
            PH_V1: cmd.load_v2 = 1'b1;
            PH_V2: begin
              cmd.load_tri = 1'b1;
              cmd.acc_clr  = 1'b1;
            end
            default: cmd.load_v1 = 1'b1;
          endcase
        end
      end
      ST_MUL:      cmd.mul_go   = 1'b1;
      ST_DET_TAKE: cmd.det_take = 1'b1;
      ST_DET_CHK:  cmd.acc_clr  = !stat.det_zero;
      ST_NUM_PREP: cmd.num_prep = 1'b1;
      ST_OVF_CHK:  cmd.ovf_chk  = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_STORE: begin
        cmd.res_store = 1'b1;
        cmd.acc_clr   = (term_r != TERM_BZ);
      end
      ST_DONE:     cmd.out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign dig       = dig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_V0;
      term_r      <= TERM_DET;
      dig_r       <= '0;
      second_r    <= 1'b0;
      qcnt_r      <= '0;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      term_r      <= term_nxt;
      dig_r       <= dig_nxt;
      second_r    <= second_nxt;
      qcnt_r      <= qcnt_nxt;
      degen_r     <= degen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ttf_dpath.sv -----
// Datapath for the triangle tangent frame: held vertices, edges and UV deltas,
// digit-serial multiply-accumulate for the cross products, restoring divider,
// saturation and the output register. Depends on ttf_pkg.
module ttf_dpath
  import ttf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int EW    = DATA_WIDTH + 1,
  localparam int ND    = (EW + MUL_DIGIT - 1) / MUL_DIGIT,
  localparam int DIG_W = (ND > 1) ? $clog2(ND) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ttf_cmd_t                     cmd,
  input  logic [DIG_W-1:0]             dig,
  output ttf_stat_t                    stat,
  input  logic signed [DATA_WIDTH-1:0] in_pos_x,
  input  logic signed [DATA_WIDTH-1:0] in_pos_y,
  input  logic signed [DATA_WIDTH-1:0] in_pos_z,
  input  logic signed [DATA_WIDTH-1:0] in_tex_u,
  input  logic signed [DATA_WIDTH-1:0] in_tex_v,
  output logic signed [DATA_WIDTH-1:0] out_tangent_x,
  output logic signed [DATA_WIDTH-1:0] out_tangent_y,
  output logic signed [DATA_WIDTH-1:0] out_tangent_z,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_x,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_y,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_z,
  output logic                         out_degenerate,
  output logic                         out_saturated
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = 2 * W + 3;                  // exact cross product / det
  localparam int BW = ND * MUL_DIGIT;             // multiplier operand split into digits
  localparam int PW = EW + MUL_DIGIT + 1;         // one partial product
  localparam int QB = W + 1;                      // quotient bits developed
  localparam int NW = XW + FRAC_BITS;             // shifted dividend
  localparam int HW = NW - QB;                    // dividend bits above the quotient field
  localparam int RW = ((HW > XW) ? HW : XW) + 1;  // partial remainder

  localparam logic [QB-1:0] LIM_POS = {2'b00, {(W - 1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W - 1){1'b0}}};

  // Held vertices and the current vertex
  logic signed [W-1:0]  hpos_r [6];
  logic signed [W-1:0]  htex_r [4];
  logic signed [W-1:0]  vin_pos [3];

  // Edges and UV deltas
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] du1_r, dv1_r, du2_r, dv2_r;

  // Multiply-accumulate
  logic signed [EW-1:0]      op_a, op_b, op_c, op_d;
  logic signed [EW-1:0]      mx, my;
  logic signed [BW-1:0]      my_ext;
  logic [MUL_DIGIT-1:0]      dig_bits;
  logic signed [MUL_DIGIT:0] dig_s;
  logic signed [PW-1:0]      prod;
  logic signed [XW-1:0]      prod_ext;
  logic signed [XW-1:0]      pp_r;
  logic                      pp_v_r;
  logic                      pp_neg_r;
  logic signed [XW-1:0]      acc_r;
  logic [XW-1:0]             acc_mag;
  logic [NW-1:0]             num_sh;

  // Divider
  logic [XW-1:0] det_mag_r;
  logic          det_neg_r;
  logic [RW-1:0] rem_r;
  logic [QB-1:0] qsh_r;
  logic [QB-1:0] quot_r;
  logic          qneg_r;
  logic          ovf_r;
  logic [RW-1:0] dm;
  logic [RW-1:0] trial;
  logic          ge;

  // Saturation and results
  logic [QB-1:0]       lim;
  logic                sat_now;
  logic [QB-1:0]       mag;
  logic [QB-1:0]       mag_neg;
  logic signed [W-1:0] res_val;
  logic [2:0]          slot;
  logic signed [W-1:0] res_r [6];
  logic                sat_acc_r;
  logic signed [W-1:0] out_vec_r [6];
  logic                out_degen_r;
  logic                out_sat_r;

  assign vin_pos[0] = in_pos_x;
  assign vin_pos[1] = in_pos_y;
  assign vin_pos[2] = in_pos_z;

  // Vertex capture; edges and deltas are formed as the third vertex arrives
  always_ff @(posedge clk) begin
    if (cmd.load_v1) begin
      for (int i = 0; i < 3; i++) hpos_r[i] <= vin_pos[i];
      htex_r[0] <= in_tex_u;
      htex_r[1] <= in_tex_v;
    end
    if (cmd.load_v2) begin
      for (int i = 0; i < 3; i++) hpos_r[3 + i] <= vin_pos[i];
      htex_r[2] <= in_tex_u;
      htex_r[3] <= in_tex_v;
    end
    if (cmd.load_tri) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(hpos_r[3 + i]) - EW'(hpos_r[i]);
        e2_r[i] <= EW'(vin_pos[i]) - EW'(hpos_r[i]);
      end
      du1_r <= EW'(htex_r[2]) - EW'(htex_r[0]);
      dv1_r <= EW'(htex_r[3]) - EW'(htex_r[1]);
      du2_r <= EW'(in_tex_u) - EW'(htex_r[0]);
      dv2_r <= EW'(in_tex_v) - EW'(htex_r[1]);
    end
  end

  // Operands of a*b - c*d for the selected term
  always_comb begin
    unique case (cmd.term)
      TERM_TX: begin op_a = dv2_r; op_b = e1_r[0]; op_c = dv1_r; op_d = e2_r[0]; end
      TERM_TY: begin op_a = dv2_r; op_b = e1_r[1]; op_c = dv1_r; op_d = e2_r[1]; end
      TERM_TZ: begin op_a = dv2_r; op_b = e1_r[2]; op_c = dv1_r; op_d = e2_r[2]; end
      TERM_BX: begin op_a = du1_r; op_b = e2_r[0]; op_c = du2_r; op_d = e1_r[0]; end
      TERM_BY: begin op_a = du1_r; op_b = e2_r[1]; op_c = du2_r; op_d = e1_r[1]; end
      TERM_BZ: begin op_a = du1_r; op_b = e2_r[2]; op_c = du2_r; op_d = e1_r[2]; end
      default: begin op_a = du1_r; op_b = dv2_r;   op_c = du2_r; op_d = dv1_r;   end
    endcase
  end

  // One partial product per cycle: full operand times one digit, top digit signed
  assign mx       = cmd.mul_second ? op_c : op_a;
  assign my       = cmd.mul_second ? op_d : op_b;
  assign my_ext   = BW'(my);
  assign dig_bits = my_ext[dig * MUL_DIGIT +: MUL_DIGIT];
  assign dig_s    = (dig == DIG_W'(ND - 1)) ? $signed({dig_bits[MUL_DIGIT-1], dig_bits})
                                             : $signed({1'b0, dig_bits});
  assign prod     = mx * dig_s;
  assign prod_ext = XW'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= cmd.mul_go;
    end
  end

  // Partial product register, then accumulate (mod 2^XW, final value is exact)
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      pp_r     <= prod_ext <<< (dig * MUL_DIGIT);
      pp_neg_r <= cmd.mul_second;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pp_v_r) begin
      acc_r <= pp_neg_r ? acc_r - pp_r : acc_r + pp_r;
    end
  end

  assign acc_mag = acc_r[XW-1] ? $unsigned(-acc_r) : $unsigned(acc_r);
  assign num_sh  = {acc_mag, {FRAC_BITS{1'b0}}};

  // Restoring division, one quotient bit per step
  assign dm    = RW'(det_mag_r);
  assign trial = {rem_r[RW-2:0], qsh_r[QB-1]};
  assign ge    = (trial >= dm);

  always_ff @(posedge clk) begin
    if (cmd.det_take) begin
      det_mag_r <= acc_mag;
      det_neg_r <= acc_r[XW-1];
    end
    if (cmd.num_prep) begin
      rem_r  <= RW'(num_sh[NW-1:QB]);
      qsh_r  <= num_sh[QB-1:0];
      qneg_r <= acc_r[XW-1] ^ det_neg_r;
    end
    // High dividend part already at or above det: quotient needs more than QB bits
    if (cmd.ovf_chk) begin
      ovf_r <= (rem_r >= dm);
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? trial - dm : trial;
      qsh_r  <= {qsh_r[QB-2:0], 1'b0};
      quot_r <= {quot_r[QB-2:0], ge};
    end
  end

  assign stat.det_zero = (det_mag_r == '0);

  // Clamp to the signed range, apply sign
  assign lim     = qneg_r ? LIM_NEG : LIM_POS;
  assign sat_now = ovf_r || (quot_r > lim);
  assign mag     = sat_now ? lim : quot_r;
  assign mag_neg = -mag;
  assign res_val = qneg_r ? $signed(mag_neg[W-1:0]) : $signed(mag[W-1:0]);
  assign slot    = 3'(cmd.term) - 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      sat_acc_r <= 1'b0;
    end else if (cmd.res_store) begin
      sat_acc_r <= sat_acc_r | sat_now;
    end
    if (cmd.res_store) begin
      res_r[slot] <= res_val;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < 6; i++) out_vec_r[i] <= cmd.degen ? '0 : res_r[i];
      out_degen_r <= cmd.degen;
      out_sat_r   <= cmd.degen ? 1'b0 : sat_acc_r;
    end
  end

  assign out_tangent_x   = out_vec_r[0];
  assign out_tangent_y   = out_vec_r[1];
  assign out_tangent_z   = out_vec_r[2];
  assign out_bitangent_x = out_vec_r[3];
  assign out_bitangent_y = out_vec_r[4];
  assign out_bitangent_z = out_vec_r[5];
  assign out_degenerate  = out_degen_r;
  assign out_saturated   = out_sat_r;

endmodule

// ----- rtl/triangle_tangent_frame.sv -----
// Triangle tangent frame: vertices in, one tangent/bitangent beat per triangle.
// First and second vertex of a triangle: captured while idle, no result.
// Third vertex: determinant, then six cross products, each divided by it in the
// restoring divider (one quotient bit per cycle); ND = ceil((DATA_WIDTH+1)/17) digits.
// Zero determinant: the beat follows the determinant alone. Input stalls while a triangle is worked on.
// Reset (synchronous, rst_n low) returns to the first vertex and drops out_valid.
module triangle_tangent_frame
  import ttf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_pos_x,
  input  logic signed [DATA_WIDTH-1:0] in_pos_y,
  input  logic signed [DATA_WIDTH-1:0] in_pos_z,
  input  logic signed [DATA_WIDTH-1:0] in_tex_u,
  input  logic signed [DATA_WIDTH-1:0] in_tex_v,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_tangent_x,
  output logic signed [DATA_WIDTH-1:0] out_tangent_y,
  output logic signed [DATA_WIDTH-1:0] out_tangent_z,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_x,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_y,
  output logic signed [DATA_WIDTH-1:0] out_bitangent_z,
  output logic                         out_degenerate,
  output logic                         out_saturated
);

  localparam int EW    = DATA_WIDTH + 1;
  localparam int ND    = (EW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int DIG_W = (ND > 1) ? $clog2(ND) : 1;

  ttf_cmd_t         cmd;
  ttf_stat_t        stat;
  logic [DIG_W-1:0] dig;

  ttf_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .dig       (dig),
    .stat      (stat)
  );

  ttf_dpath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dig             (dig),
    .stat            (stat),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_tex_u        (in_tex_u),
    .in_tex_v        (in_tex_v),
    .out_tangent_x   (out_tangent_x),
    .out_tangent_y   (out_tangent_y),
    .out_tangent_z   (out_tangent_z),
    .out_bitangent_x (out_bitangent_x),
    .out_bitangent_y (out_bitangent_y),
    .out_bitangent_z (out_bitangent_z),
    .out_degenerate  (out_degenerate),
    .out_saturated   (out_saturated)
  );

  // Datapath steps never overlap
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_v1, cmd.load_v2, cmd.load_tri, cmd.mul_go, cmd.det_take,
              cmd.num_prep, cmd.ovf_chk, cmd.div_step, cmd.res_store, cmd.out_load}))
    else $error("ttf: more than one datapath step in a cycle");

  // A new result never overwrites a beat still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("ttf: output beat overwritten while stalled");

  // Third vertex starts the triangle math and blocks further input
  a_busy_after_tri: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_tri |=> in_stall)
    else $error("ttf: input not stalled after third vertex");

  // Degenerate beats carry zero vectors and no saturation flag
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_tangent_x == '0 && out_tangent_y == '0 && out_tangent_z == '0 &&
       out_bitangent_x == '0 && out_bitangent_y == '0 && out_bitangent_z == '0 &&
       !out_saturated))
    else $error("ttf: degenerate beat with nonzero payload");

endmodule

// ----- test/triangle_tangent_frame_test.sv -----
// Testbench for triangle_tangent_frame: streams vertices and checks each
// tangent/bitangent beat against a predictor built on wide signed arithmetic.
// Depends on rtl/ttf_pkg.sv and rtl/triangle_tangent_frame.sv.
`timescale 1ns / 100ps

module triangle_tangent_frame_test;

  localparam int DW             = 32;
  localparam int FB             = 16;
  localparam int TRI_LATENCY    = 254;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NEAR_SPAN      = 1 << 19;  // +/- 8.0 in Q16.16

  typedef logic signed [127:0] wide_t;

  localparam wide_t WORD_MAX = (128'sd1 <<< (DW - 1)) - 128'sd1;
  localparam wide_t WORD_MIN = -(128'sd1 <<< (DW - 1));

  localparam logic signed [DW-1:0] W_MAX = WORD_MAX[DW-1:0];
  localparam logic signed [DW-1:0] W_MIN = WORD_MIN[DW-1:0];
  localparam logic signed [DW-1:0] Q_ONE = 1 << FB;
  localparam logic signed [DW-1:0] LSB   = 1;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
    logic signed [DW-1:0] tex_u;
    logic signed [DW-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic [2:0][DW-1:0] tangent;
    logic [2:0][DW-1:0] bitangent;
    logic               degenerate;
    logic               saturated;
  } frame_t;

  // How widely a random field is spread
  typedef enum int {
    SPREAD_NEAR,
    SPREAD_FULL,
    SPREAD_EDGE
  } spread_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_pos_x;
  logic signed [DW-1:0] in_pos_y;
  logic signed [DW-1:0] in_pos_z;
  logic signed [DW-1:0] in_tex_u;
  logic signed [DW-1:0] in_tex_v;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_tangent_x;
  logic signed [DW-1:0] out_tangent_y;
  logic signed [DW-1:0] out_tangent_z;
  logic signed [DW-1:0] out_bitangent_x;
  logic signed [DW-1:0] out_bitangent_y;
  logic signed [DW-1:0] out_bitangent_z;
  logic                 out_degenerate;
  logic                 out_saturated;

  // Predictor state: first two corners of the triangle in flight
  vertex_t corner_held [2];
  int      corners_seen;
  frame_t  frames_due [$];

  bit calm;
  int mismatches;
  int vertices_sent;
  int frames_checked;
  int degenerate_seen;
  int saturated_seen;
  int quiet_cycles;

  triangle_tangent_frame #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_tex_u       (in_tex_u),
    .in_tex_v       (in_tex_v),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tangent_x  (out_tangent_x),
    .out_tangent_y  (out_tangent_y),
    .out_tangent_z  (out_tangent_z),
    .out_bitangent_x(out_bitangent_x),
    .out_bitangent_y(out_bitangent_y),
    .out_bitangent_z(out_bitangent_z),
    .out_degenerate (out_degenerate),
    .out_saturated  (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (num * 2^FB) / det toward zero, clamped; MSB of the result flags a clamp
  function automatic logic [DW:0] scale_clamp(wide_t num, wide_t det);
    wide_t q;
    q = (num <<< FB) / det;
    if (q > WORD_MAX) return {1'b1, W_MAX};
    if (q < WORD_MIN) return {1'b1, W_MIN};
    return {1'b0, q[DW-1:0]};
  endfunction

  function automatic frame_t solve_frame(vertex_t a, vertex_t b, vertex_t c);
    logic signed [DW-1:0] pa [3];
    logic signed [DW-1:0] pb [3];
    logic signed [DW-1:0] pc [3];
    wide_t                e1 [3];
    wide_t                e2 [3];
    wide_t                du1, dv1, du2, dv2, det;
    logic [DW:0]          part;
    frame_t               f;
    pa = '{a.pos_x, a.pos_y, a.pos_z};
    pb = '{b.pos_x, b.pos_y, b.pos_z};
    pc = '{c.pos_x, c.pos_y, c.pos_z};
    f  = '0;
    // edges and UV deltas carry one bit more than the inputs
    for (int i = 0; i < 3; i++) begin
      e1[i] = pb[i] - pa[i];
      e2[i] = pc[i] - pa[i];
    end
    du1 = b.tex_u - a.tex_u;
    dv1 = b.tex_v - a.tex_v;
    du2 = c.tex_u - a.tex_u;
    dv2 = c.tex_v - a.tex_v;
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      f.degenerate = 1'b1;
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      part           = scale_clamp(dv2 * e1[i] - dv1 * e2[i], det);
      f.tangent[i]   = part[DW-1:0];
      f.saturated   |= part[DW];
      part           = scale_clamp(du1 * e2[i] - du2 * e1[i], det);
      f.bitangent[i] = part[DW-1:0];
      f.saturated   |= part[DW];
    end
    return f;
  endfunction

  // Every third accepted vertex closes a triangle and yields one frame
  task automatic track_vertex(vertex_t v);
    if (corners_seen < 2) begin
      corner_held[corners_seen] = v;
      corners_seen++;
    end else begin
      frames_due.push_back(solve_frame(corner_held[0], corner_held[1], v));
      corners_seen = 0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic push_vertex(vertex_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= v.pos_x;
    in_pos_y <= v.pos_y;
    in_pos_z <= v.pos_z;
    in_tex_u <= v.tex_u;
    in_tex_v <= v.tex_v;
    do @(posedge clk); while (in_stall);
    track_vertex(v);
    vertices_sent++;
    @(negedge clk);
  endtask

  function automatic vertex_t vtx(logic signed [DW-1:0] x, y, z, u, v);
    vtx = '{x, y, z, u, v};
  endfunction

  task automatic send_tri(vertex_t a, vertex_t b, vertex_t c);
    push_vertex(a);
    push_vertex(b);
    push_vertex(c);
  endtask

  function automatic logic signed [DW-1:0] pick_word(spread_t spread);
    case (spread)
      SPREAD_NEAR: return $urandom_range(0, 2 * NEAR_SPAN) - NEAR_SPAN;
      SPREAD_FULL: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return '1;
          4: return LSB;
          default: return Q_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic spread_t pick_spread();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return SPREAD_NEAR;
    if (roll < 9) return SPREAD_FULL;
    return SPREAD_EDGE;
  endfunction

  // Random triangle; a share of them get a zero UV determinant on purpose
  task automatic send_random_tri();
    vertex_t     k [3];
    spread_t     ps, ts;
    int unsigned roll;
    ps = pick_spread();
    ts = pick_spread();
    for (int i = 0; i < 3; i++)
      k[i] = vtx(pick_word(ps), pick_word(ps), pick_word(ps), pick_word(ts), pick_word(ts));
    roll = $urandom_range(0, 11);
    if (roll == 0) begin
      k[2].tex_u = k[0].tex_u;
      k[2].tex_v = k[0].tex_v;
    end else if (roll == 1) begin
      k[1].tex_u = k[0].tex_u;
      k[1].tex_v = k[0].tex_v;
    end else if (roll == 2) begin
      // third UV on the line through the first two
      k[2].tex_u = k[1].tex_u + (k[1].tex_u - k[0].tex_u);
      k[2].tex_v = k[1].tex_v + (k[1].tex_v - k[0].tex_v);
    end
    send_tri(k[0], k[1], k[2]);
  endtask

  // Axis-aligned UVs (tangent along x, bitangent along y), then an arbitrary triangle
  task automatic test_unit_frame();
    send_tri(vtx(0, 0, 0, 0, 0), vtx(Q_ONE, 0, 0, Q_ONE, 0), vtx(0, Q_ONE, 0, 0, Q_ONE));
    send_tri(vtx(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE / 2, Q_ONE / 4),
             vtx(-Q_ONE, 5 * Q_ONE, 7, -Q_ONE, 3 * Q_ONE),
             vtx(9 * Q_ONE, -Q_ONE, Q_ONE, 2 * Q_ONE, -Q_ONE / 3));
  endtask

  // Swapped UV axes give a negative determinant
  task automatic test_mirrored_uv();
    send_tri(vtx(0, 0, 0, 0, 0), vtx(Q_ONE, 0, 0, 0, Q_ONE), vtx(0, Q_ONE, 0, Q_ONE, 0));
  endtask

  // Zero determinant: all UVs equal, then first two UVs equal
  task automatic test_degenerate();
    send_tri(vtx(Q_ONE, 0, 0, 3, 3), vtx(0, Q_ONE, 0, 3, 3), vtx(0, 0, Q_ONE, 3, 3));
    send_tri(vtx(W_MAX, W_MIN, 0, W_MIN, W_MAX), vtx(0, 0, 0, W_MIN, W_MAX),
             vtx(5, 6, 7, 0, 0));
  endtask

  // Tiny determinant against full-range edges clamps both ways
  task automatic test_saturation();
    send_tri(vtx(W_MIN, W_MIN, W_MIN, 0, 0), vtx(W_MAX, W_MAX, W_MAX, LSB, 0),
             vtx(0, 0, 0, 0, LSB));
    send_tri(vtx(W_MAX, 0, W_MIN, 0, 0), vtx(W_MIN, 0, W_MAX, LSB, 0),
             vtx(W_MAX, W_MIN, 0, 0, -LSB));
  endtask

  // Fields at their extremes (and at -1), with UV deltas one bit wider than a word
  task automatic test_field_extremes();
    send_tri(vtx(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN), vtx(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN),
             vtx(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX));
    send_tri(vtx(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX), vtx(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX),
             vtx('1, '1, '1, W_MAX, W_MIN));
  endtask

  task automatic test_random_mesh();
    repeat (205) send_random_tri();
  endtask

  // Closing stretch: no input gaps and no result-side back-pressure
  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (24) send_random_tri();
  endtask

  // Result-side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_word(string field, logic [DW-1:0] want, logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest predicted frame
  always @(posedge clk) begin : check_beat
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("result beat with no triangle pending");
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        check_word("tangent_x", want.tangent[0], out_tangent_x);
        check_word("tangent_y", want.tangent[1], out_tangent_y);
        check_word("tangent_z", want.tangent[2], out_tangent_z);
        check_word("bitangent_x", want.bitangent[0], out_bitangent_x);
        check_word("bitangent_y", want.bitangent[1], out_bitangent_y);
        check_word("bitangent_z", want.bitangent[2], out_bitangent_z);
        check_word("degenerate", DW'(want.degenerate), DW'(out_degenerate));
        check_word("saturated", DW'(want.saturated), DW'(out_saturated));
        frames_checked++;
        if (want.degenerate) degenerate_seen++;
        if (want.saturated) saturated_seen++;
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_tex_u <= '0;
    in_tex_v <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unit_frame();
    test_mirrored_uv();
    test_degenerate();
    test_saturation();
    test_field_extremes();
    test_random_mesh();
    test_steady_stream();
    in_valid <= 1'b0;

    // drain, then watch a while longer for stray beats
    while (frames_due.size() != 0) @(posedge clk);
    repeat (2 * TRI_LATENCY) @(posedge clk);

    $display("%0d vertices in, %0d frames compared", vertices_sent, frames_checked);
    $display("%0d zero-determinant frames, %0d clamped frames", degenerate_seen,
             saturated_seen);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- triangle_tangent_frame.f -----
rtl/ttf_pkg.sv
rtl/ttf_ctrl.sv
rtl/ttf_dpath.sv
rtl/triangle_tangent_frame.sv
test/triangle_tangent_frame_test.sv
